[rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/mvsm_pkg.sv]
package mvsm_pkg;

  localparam int VOICES       = 8;
  localparam int SAMPLE_DEPTH = 4096;
  localparam int DUTY_BITS    = 8;

  localparam int VIDX_W  = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int PLAY_W  = $clog2(VOICES + 1);
  localparam int ADDR_W  = $clog2(SAMPLE_DEPTH);

  localparam int IN_Q_DEPTH = 2;
  localparam int QPTR_W     = 1;
  localparam int QCNT_W     = 2;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_AMP_PRESENT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AMP_INVERT  = 8'd1;

  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_QUEUE = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;

  localparam logic [3:0] AMP_HOLD     = 4'd10;
  localparam logic [7:0] DUTY_RESET   = 8'd128;
  localparam logic [7:0] GAIN_UNITY   = 8'd255;
  localparam logic [15:0] RECIP_255   = 16'd32896;

  typedef struct packed {
    logic [1:0]         action;
    logic [11:0]        address;
    logic signed [15:0] sample_word;
    logic [12:0]        length;
    logic [15:0]        delay;
    logic signed [7:0]  speed;
    logic [7:0]         volume;
    logic               single_only;
  } in_item_t;

  typedef struct packed {
    logic       accepted;
    logic [7:0] duty;
    logic       duty_updated;
    logic       amp_level;
    logic [3:0] voices_playing;
  } out_item_t;

  typedef struct packed {
    logic              accepted;
    logic [7:0]        duty;
    logic              duty_updated;
    logic              amp_state;
    logic [PLAY_W-1:0] voices_playing;
  } eng_res_t;

endpackage

[rtl/mvsm_front.sv]
module mvsm_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  mvsm_pkg::in_item_t item,
  output logic               cmd_valid,
  input  logic               cmd_pop,
  output mvsm_pkg::in_item_t cmd
);
  import mvsm_pkg::*;

  in_item_t          q_r [IN_Q_DEPTH];
  logic [QPTR_W-1:0] wptr_r;
  logic [QPTR_W-1:0] rptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_push;
  logic              do_pop;

  assign full      = (cnt_r == QCNT_W'(IN_Q_DEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rptr_r];
  assign do_push   = push && !full;
  assign do_pop    = cmd_pop && cmd_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (do_pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wptr_r] <= item;
    end
  end

endmodule

[rtl/mvsm_engine.sv]
module mvsm_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  output logic               cmd_pop,
  input  mvsm_pkg::in_item_t cmd,
  output logic               res_valid,
  input  logic               res_ready,
  output mvsm_pkg::eng_res_t res
);
  import mvsm_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_VOICE = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_MIX   = 3'd4;
  localparam logic [2:0] ST_ACC   = 3'd5;
  localparam logic [2:0] ST_FIN   = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  logic [2:0]        state_r;
  logic [VIDX_W-1:0] vidx_r;
  logic              last_voice;

  logic              active_r [VOICES];
  logic [11:0]       start_r  [VOICES];
  logic [12:0]       length_r [VOICES];
  logic [15:0]       wait_r   [VOICES];
  logic [12:0]       pos_r    [VOICES];
  logic signed [7:0] step_r   [VOICES];
  logic signed [8:0] phase_r  [VOICES];
  logic [7:0]        gain_r   [VOICES];

  logic signed [15:0] mem [SAMPLE_DEPTH];
  logic signed [15:0] rd_data_r;
  logic               mem_we;
  logic               mem_re;
  logic [ADDR_W-1:0]  raddr;

  logic              dup;
  logic              found;
  logic [VIDX_W-1:0] fidx;
  logic              q_take;
  logic              q_we;

  logic              play;
  logic [13:0]       pos1;
  logic [13:0]       pos2;
  logic signed [8:0] ph_sum;
  logic signed [8:0] ph_nxt;
  logic              done;

  logic               accepted_r;
  logic               updated_r;
  logic [PLAY_W-1:0]  playing_r;
  logic [7:0]         held_r;
  logic [3:0]         hold_r;
  logic               amp_r;

  logic [7:0]         vgain_r;
  logic signed [15:0] samp_r;
  logic signed [24:0] prod_r;
  logic signed [24:0] prod_nxt;
  logic               bypass_r;
  logic [22:0]        mag_r;
  logic               neg_r;
  logic [24:0]        mag_full;
  logic [38:0]        qm;
  logic [15:0]        qest_r;
  logic [23:0]        q255;
  logic [23:0]        rem;
  logic [15:0]        qc;
  logic signed [15:0] scaled;
  logic [16:0]        fa;
  logic [15:0]        fb;
  logic [32:0]        mixp_r;
  logic               low_r;
  logic [17:0]        sum_r;
  logic [19:0]        fz;
  logic signed [16:0] acc_r;
  logic signed [16:0] acc_nxt;
  logic signed [15:0] acc_c;
  logic [15:0]        acc_u;
  logic [7:0]         duty_nxt;

  assign last_voice = (vidx_r == VIDX_W'(VOICES - 1));
  assign cmd_pop    = (state_r == ST_IDLE) && cmd_valid;
  assign res_valid  = (state_r == ST_DONE);

  assign res.accepted       = accepted_r;
  assign res.duty           = held_r;
  assign res.duty_updated   = updated_r;
  assign res.amp_state      = amp_r;
  assign res.voices_playing = playing_r;

  always_comb begin
    dup   = 1'b0;
    found = 1'b0;
    fidx  = '0;
    for (int i = 0; i < VOICES; i++) begin
      if (active_r[i] && (start_r[i] == cmd.address)) begin
        dup = 1'b1;
      end
      if (!active_r[i] && !found) begin
        found = 1'b1;
        fidx  = VIDX_W'(i);
      end
    end
    q_take = !(dup && cmd.single_only) && found;
  end

  assign q_we   = cmd_pop && (cmd.action == ACT_QUEUE) && q_take;
  assign mem_we = cmd_pop && (cmd.action == ACT_WRITE);

  assign play   = (state_r == ST_VOICE) && active_r[vidx_r] && (wait_r[vidx_r] == '0);
  assign mem_re = play;
  assign raddr  = ADDR_W'({2'b00, start_r[vidx_r]} + {1'b0, pos_r[vidx_r]});

  always_comb begin
    pos1   = {1'b0, pos_r[vidx_r]} + 14'd1;
    ph_sum = phase_r[vidx_r] + 9'(step_r[vidx_r]);
    pos2   = pos1;
    ph_nxt = ph_sum;
    if (ph_sum > 9'sd100) begin
      pos2   = pos1 + 14'd1;
      ph_nxt = '0;
    end else if (ph_sum < -9'sd100) begin
      pos2   = pos1 - 14'd1;
      ph_nxt = '0;
    end
    done = (pos2 >= {1'b0, length_r[vidx_r]});
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[ADDR_W'(cmd.address)] <= cmd.sample_word;
    end
    if (mem_re) begin
      rd_data_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      start_r[fidx]  <= cmd.address;
      length_r[fidx] <= cmd.length;
      wait_r[fidx]   <= cmd.delay;
      pos_r[fidx]    <= '0;
      step_r[fidx]   <= cmd.speed;
      phase_r[fidx]  <= '0;
      gain_r[fidx]   <= cmd.volume;
    end
    if ((state_r == ST_VOICE) && active_r[vidx_r] && (wait_r[vidx_r] != '0)) begin
      wait_r[vidx_r] <= wait_r[vidx_r] - 16'd1;
    end
    if (play) begin
      pos_r[vidx_r]   <= pos2[12:0];
      phase_r[vidx_r] <= ph_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < VOICES; i++) begin
        active_r[i] <= 1'b0;
      end
    end else if (q_we) begin
      active_r[fidx] <= 1'b1;
    end else if (play) begin
      active_r[vidx_r] <= !done;
    end
  end

  assign prod_nxt = $signed({{9{rd_data_r[15]}}, rd_data_r}) * $signed({17'd0, vgain_r});
  assign mag_full = prod_r[24] ? 25'(-prod_r) : 25'(prod_r);
  assign qm       = {16'd0, mag_full[22:0]} * {23'd0, RECIP_255};

  always_comb begin
    q255   = {qest_r, 8'd0} - {8'd0, qest_r};
    rem    = {1'b0, mag_r} - q255;
    qc     = (rem >= 24'd255) ? (qest_r + 16'd1) : qest_r;
    if (bypass_r) begin
      scaled = samp_r;
    end else if (neg_r) begin
      scaled = 16'(16'd0 - qc);
    end else begin
      scaled = qc;
    end
    fa = 17'(acc_r + 17'sh08000);
    fb = {~scaled[15], scaled[14:0]};
  end

  always_comb begin
    if (low_r) begin
      fz = {2'b00, mixp_r[32:15]};
    end else begin
      fz = {1'b0, sum_r, 1'b0} - {2'b00, mixp_r[32:15]} - 20'd65536;
    end
    acc_nxt = 17'(fz - 20'd32768);
    if (acc_r > 17'sd32767) begin
      acc_c = 16'sh7fff;
    end else if (acc_r < -17'sd32768) begin
      acc_c = 16'sh8000;
    end else begin
      acc_c = acc_r[15:0];
    end
    acc_u    = {~acc_c[15], acc_c[14:0]};
    duty_nxt = 8'(acc_u >> (16 - DUTY_BITS));
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        acc_r <= '0;
      end
      ST_VOICE: begin
        vgain_r <= gain_r[vidx_r];
      end
      ST_MUL: begin
        prod_r   <= prod_nxt;
        samp_r   <= rd_data_r;
        bypass_r <= (vgain_r == GAIN_UNITY);
      end
      ST_DIV: begin
        mag_r  <= mag_full[22:0];
        neg_r  <= prod_r[24];
        qest_r <= qm[38:23];
      end
      ST_MIX: begin
        mixp_r <= {16'd0, fa} * {17'd0, fb};
        low_r  <= !fa[16] && !fa[15] && !fb[15];
        sum_r  <= {1'b0, fa} + {2'b00, fb};
      end
      ST_ACC: begin
        acc_r <= acc_nxt;
      end
      default: begin
      end
    endcase
  end

  // The quotient estimate for the divide by 255 may be one low and is corrected in the mix state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      vidx_r     <= '0;
      accepted_r <= 1'b0;
      updated_r  <= 1'b0;
      playing_r  <= '0;
      held_r     <= DUTY_RESET;
      hold_r     <= '0;
      amp_r      <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (cmd_valid) begin
            accepted_r <= 1'b0;
            updated_r  <= 1'b0;
            playing_r  <= '0;
            vidx_r     <= '0;
            if (cmd.action == ACT_QUEUE) begin
              accepted_r <= q_take;
              state_r    <= ST_DONE;
            end else if (cmd.action == ACT_TICK) begin
              state_r <= ST_VOICE;
            end else begin
              state_r <= ST_DONE;
            end
          end
        end
        ST_VOICE: begin
          if (play) begin
            playing_r <= playing_r + 1'b1;
            state_r   <= ST_MUL;
          end else if (last_voice) begin
            state_r <= ST_FIN;
          end else begin
            vidx_r <= vidx_r + 1'b1;
          end
        end
        ST_MUL: begin
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          state_r <= ST_MIX;
        end
        ST_MIX: begin
          state_r <= ST_ACC;
        end
        ST_ACC: begin
          if (last_voice) begin
            state_r <= ST_FIN;
          end else begin
            vidx_r  <= vidx_r + 1'b1;
            state_r <= ST_VOICE;
          end
        end
        ST_FIN: begin
          if (playing_r != '0) begin
            held_r    <= duty_nxt;
            updated_r <= 1'b1;
            hold_r    <= AMP_HOLD - 4'd1;
            amp_r     <= 1'b1;
          end else if (hold_r != '0) begin
            hold_r <= hold_r - 4'd1;
            if (hold_r == 4'd1) begin
              amp_r <= 1'b0;
            end
          end
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (res_ready) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/multi_voice_sample_mixer.sv]
// Eight-voice sample player and mixer. Requests enter a two-entry queue and are carried out one
// at a time by a sequencer that owns the voice table and the 4096-word sample store. A sample
// write, a voice queue or a no-operation request is carried out as it is popped in the idle state,
// and the done state then hands the result over. A tick walks the voices in turn: an idle or
// delayed voice is passed over in the voice state, while a playing voice goes through store read,
// gain multiply, divide by 255, mix multiply and mix finish. A final state then clamps the mix
// before the done state reports it. The result register lets the next request start while a
// result waits to be popped. No clearing pass is run after reset; the sample store holds garbage
// until written.
module multi_voice_sample_mixer (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  output logic                              in_full,
  input  mvsm_pkg::in_item_t                in_item,
  output logic                              out_empty,
  input  logic                              out_pop,
  output mvsm_pkg::out_item_t               out_item,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mvsm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mvsm_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import mvsm_pkg::*;
  `include "assert_macros.svh"

  logic      cmd_valid;
  logic      cmd_pop;
  in_item_t  cmd;
  logic      res_valid;
  logic      res_ready;
  eng_res_t  res;

  logic      amp_present_r;
  logic      amp_invert_r;
  logic      out_valid_r;
  out_item_t out_r;

  mvsm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_push),
    .full      (in_full),
    .item      (in_item),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd)
  );

  mvsm_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign cfg_ready = 1'b1;
  assign res_ready = !out_valid_r || out_pop;
  assign out_empty = !out_valid_r;
  assign out_item  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amp_present_r <= 1'b0;
      amp_invert_r  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_AMP_PRESENT) begin
        amp_present_r <= cfg_data[0];
      end else if (cfg_index == CFG_AMP_INVERT) begin
        amp_invert_r <= cfg_data[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r.accepted       <= res.accepted;
      out_r.duty           <= res.duty;
      out_r.duty_updated   <= res.duty_updated;
      out_r.amp_level      <= amp_present_r && (res.amp_state ^ amp_invert_r);
      out_r.voices_playing <= 4'(res.voices_playing);
    end
  end

  `ASSERT_IMPLIES(a_acc_upd_excl, !out_empty, !(out_item.accepted && out_item.duty_updated))
  `ASSERT_IMPLIES(a_amp_on_update, !out_empty && out_item.duty_updated,
                  out_item.amp_level == (amp_present_r && !amp_invert_r))
  `ASSERT_NEXT(a_result_holds, out_valid_r && !out_pop, out_valid_r && $stable(out_r))

endmodule

[sim/multi_voice_sample_mixer_test.sv]
`timescale 1ns / 1ps

module multi_voice_sample_mixer_test;
  import mvsm_pkg::*;

  localparam int STALL_LIMIT = 3000;

  logic clk = 1'b0;
  logic rst_n;
  logic in_push;
  logic in_full;
  in_item_t in_item;
  logic out_empty;
  logic out_pop;
  out_item_t out_item;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  multi_voice_sample_mixer u_top (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_item(in_item),
    .out_empty(out_empty), .out_pop(out_pop), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // Mixer state as the testbench expects it.
  bit m_amp_present, m_amp_invert;
  bit v_on[VOICES];
  int v_start[VOICES], v_len[VOICES], v_wait[VOICES], v_pos[VOICES];
  int v_step[VOICES], v_phase[VOICES], v_gain[VOICES];
  logic signed [15:0] mem_word[SAMPLE_DEPTH];
  int duty_held = 128;
  int hold_count = 0;
  bit amp_on = 0;

  out_item_t expected_q[$];
  int errors = 0;
  bit no_idle = 0;
  bit long_hold_req = 0;
  int stall_cycles = 0;

  function automatic out_item_t mix_predict(in_item_t it);
    out_item_t r;
    bit dup;
    int acc, s, playing;
    longint fa, fb, fz;
    r = '0;
    playing = 0;
    case (it.action)
      ACT_WRITE: mem_word[it.address] = it.sample_word;
      ACT_QUEUE: begin
        dup = 0;
        if (it.single_only)
          for (int i = 0; i < VOICES; i++)
            if (v_on[i] && v_start[i] == int'(it.address)) dup = 1;
        if (!dup)
          for (int i = 0; i < VOICES; i++)
            if (!v_on[i]) begin
              v_on[i] = 1;
              v_start[i] = it.address;
              v_len[i] = it.length;
              v_wait[i] = it.delay;
              v_pos[i] = 0;
              v_step[i] = int'(it.speed);
              v_phase[i] = 0;
              v_gain[i] = it.volume;
              r.accepted = 1'b1;
              break;
            end
      end
      ACT_TICK: begin
        acc = 0;
        for (int i = 0; i < VOICES; i++) begin
          if (!v_on[i]) continue;
          if (v_wait[i] > 0) begin
            v_wait[i]--;
            continue;
          end
          playing++;
          s = int'(mem_word[(v_start[i] + v_pos[i]) % SAMPLE_DEPTH]);
          if (v_gain[i] < 255) s = (s * v_gain[i]) / 255;
          fa = longint'(acc) + 32768;
          fb = longint'(s) + 32768;
          if (fa < 32768 && fb < 32768) fz = (fa * fb) / 32768;
          else fz = 2 * (fa + fb) - (fa * fb) / 32768 - 65536;
          acc = int'(fz - 32768);
          v_pos[i]++;
          v_phase[i] += v_step[i];
          if (v_phase[i] > 100) begin
            v_pos[i]++;
            v_phase[i] = 0;
          end
          if (v_phase[i] < -100) begin
            v_pos[i]--;
            v_phase[i] = 0;
          end
          if (v_pos[i] >= v_len[i]) v_on[i] = 0;
        end
        if (playing > 0) begin
          if (acc < -32768) acc = -32768;
          if (acc > 32767) acc = 32767;
          duty_held = (acc + 32768) >> (16 - DUTY_BITS);
          r.duty_updated = 1'b1;
          amp_on = 1;
          hold_count = 10;
        end
        if (hold_count > 0) begin
          hold_count--;
          if (hold_count == 0) amp_on = 0;
        end
      end
      default: ;
    endcase
    r.duty = duty_held[7:0];
    r.amp_level = m_amp_present ? (amp_on ^ m_amp_invert) : 1'b0;
    r.voices_playing = playing[3:0];
    return r;
  endfunction

  function automatic in_item_t rand_item(logic [1:0] act);
    in_item_t it;
    it = in_item_t'({$urandom, $urandom, $urandom});
    it.action = act;
    it.length = 13'($urandom_range(0, 31));
    it.delay = 16'($urandom_range(0, 7));
    return it;
  endfunction

  task automatic send_item(in_item_t it);
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_item <= it;
    in_push <= 1'b1;
    @(posedge clk);
    while (in_full) @(posedge clk);
    expected_q.push_back(mix_predict(it));
  endtask

  task automatic settle();
    in_push <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, bit val);
    settle();
    cfg_index <= idx;
    cfg_data <= {7'($urandom), val};
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_AMP_PRESENT) m_amp_present = val;
    else m_amp_invert = val;
  endtask

  task automatic send_queue(int addr, int len, int dly, int spd, int vol, bit single);
    in_item_t it;
    it = rand_item(ACT_QUEUE);
    it.address = 12'(addr);
    it.length = 13'(len);
    it.delay = 16'(dly);
    it.speed = 8'(spd);
    it.volume = 8'(vol);
    it.single_only = single;
    send_item(it);
  endtask

  task automatic write_word(int a);
    in_item_t it;
    it = rand_item(ACT_WRITE);
    it.address = 12'(a);
    if (a == 0 || (a >= 480 && a < 496)) it.sample_word = -16'sd32768;
    else if (a == SAMPLE_DEPTH - 1 || (a >= 460 && a < 476)) it.sample_word = 16'sd32767;
    send_item(it);
  endtask

  task automatic test_fill_store();
    for (int a = 0; a < 512; a++) begin
      write_word(a);
    end
    write_word(SAMPLE_DEPTH - 1);
  endtask

  task automatic test_directed();
    in_item_t it;
    write_reg(CFG_AMP_PRESENT, 1);
    write_reg(CFG_AMP_INVERT, 0);
    send_queue(0, 0, 0, 0, 255, 0);
    send_queue(0, 3, 0, 0, 255, 1);
    send_queue(100, 5, 0, 127, 0, 1);
    send_queue(200, 5, 0, -127, 128, 0);
    send_queue(4095, 3, 2, 101, 255, 0);
    send_queue(300, 4, 0, -101, 77, 0);
    send_queue(350, 2, 0, -128, 200, 0);
    send_queue(460, 2, 0, 0, 255, 0);
    send_queue(461, 2, 0, 0, 255, 0);
    send_queue(250, 2, 0, 0, 255, 0);
    repeat (8) send_item(rand_item(ACT_TICK));
    it = rand_item(2'd3);
    send_item(it);
    send_queue(480, 1, 0, 50, 255, 0);
    send_queue(481, 1, 0, -50, 255, 0);
    repeat (12) send_item(rand_item(ACT_TICK));
  endtask

  task automatic test_long_voices();
    write_reg(CFG_AMP_INVERT, 1);
    send_queue(0, 450, 0, 0, 255, 0);
    send_queue(20, 480, 0, 10, 100, 0);
    repeat (455) send_item(rand_item(ACT_TICK));
  endtask

  task automatic random_items(int count);
    in_item_t it;
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 20) it = rand_item(ACT_WRITE);
      else if (pick < 45) begin
        it = rand_item(ACT_QUEUE);
        it.address = 12'($urandom_range(0, 300));
        if ($urandom_range(0, 3) == 0) it.address = 12'(460 + $urandom_range(0, 15));
        else if ($urandom_range(0, 15) == 0) it.length = 13'($urandom_range(0, 200));
      end else if (pick < 97) it = rand_item(ACT_TICK);
      else it = rand_item(2'd3);
      send_item(it);
    end
  endtask

  task automatic test_random();
    write_reg(CFG_AMP_PRESENT, 0);
    random_items(225);
    write_reg(CFG_AMP_PRESENT, 1);
    write_reg(CFG_AMP_INVERT, 0);
    long_hold_req = 1;
    random_items(225);
    write_reg(CFG_AMP_INVERT, 1);
    random_items(225);
    write_reg(CFG_AMP_INVERT, 0);
    random_items(75);
    no_idle = 1;
    random_items(150);
  endtask

  task automatic test_max_delay();
    send_queue(3000, 2, 65535, 0, 255, 1);
    repeat (3) send_item(rand_item(ACT_TICK));
  endtask

  initial begin
    int hold_left;
    hold_left = 0;
    out_pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_pop && !out_empty) begin
        if (expected_q.size() == 0) begin
          $error("result with nothing expected");
          errors++;
        end else begin
          out_item_t e;
          e = expected_q.pop_front();
          if (out_item.accepted !== e.accepted) begin
            $error("accepted: expected %0d actual %0d", e.accepted, out_item.accepted);
            errors++;
          end
          if (out_item.duty !== e.duty) begin
            $error("duty: expected %0d actual %0d", e.duty, out_item.duty);
            errors++;
          end
          if (out_item.duty_updated !== e.duty_updated) begin
            $error("duty_updated: expected %0d actual %0d", e.duty_updated,
                   out_item.duty_updated);
            errors++;
          end
          if (out_item.amp_level !== e.amp_level) begin
            $error("amp_level: expected %0d actual %0d", e.amp_level, out_item.amp_level);
            errors++;
          end
          if (out_item.voices_playing !== e.voices_playing) begin
            $error("voices_playing: expected %0d actual %0d", e.voices_playing,
                   out_item.voices_playing);
            errors++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 0;
        hold_left = 300;
        out_pop <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        hold_left = $urandom_range(0, 13);
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if ((in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("multi_voice_sample_mixer test failed");
        $finish;
      end
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_push <= 1'b0;
    in_item <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_fill_store();
    test_directed();
    test_long_voices();
    test_random();
    test_max_delay();
    settle();
    if (errors == 0 && expected_q.size() == 0) begin
      $display("multi_voice_sample_mixer test passed");
    end else begin
      $display("multi_voice_sample_mixer test failed");
    end
    $finish;
  end

endmodule
